@@ rtl/mlpd_pkg.sv @@
package mlpd_pkg;

  localparam int unsigned POS_W = 32;

  localparam logic [1:0] MODE_BIT        = 2'd0;
  localparam logic [1:0] MODE_TICK       = 2'd1;
  localparam logic [1:0] MODE_START_KEEP = 2'd2;
  localparam logic [1:0] MODE_START_CLR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNEXPECT  = 2'd1;
  localparam logic [1:0] ST_BEFORE    = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam logic CFG_LINE_WIDTH = 1'b0;
  localparam logic CFG_LINE_COUNT = 1'b1;

  localparam logic [63:0] ID_ROW = 64'h0706050403020100;

  typedef struct packed {
    logic       commit;
    logic       is_index;
    logic [7:0] val;
  } mtf_req_t;

endpackage

@@ rtl/mlpd_history.sv @@
module mlpd_history #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;
endmodule

@@ rtl/mlpd_rows.sv @@
module mlpd_rows (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        raddr_i,
  input  logic [7:0]        cur_i,
  input  logic              clear_i,
  input  mlpd_pkg::mtf_req_t req_i,
  output logic [7:0]        value_o
);
  import mlpd_pkg::*;

  logic [63:0]  mem [256];
  logic [63:0]  rd_q;
  logic [255:0] fresh_q;
  logic [63:0]  row;
  logic [63:0]  row_new;
  logic [7:0]   e [8];
  logic [7:0]   value;
  logic [2:0]   p;

  assign row = fresh_q[cur_i] ? ID_ROW : rd_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      e[i] = row[8*i +: 8];
    end
    value = req_i.is_index ? e[req_i.val[2:0]] : req_i.val;
    p = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (e[i] == value) begin
        p = 3'(i);
      end
    end
    row_new[7:0] = value;
    for (int i = 1; i < 8; i++) begin
      row_new[8*i +: 8] = (3'(i) <= p) ? e[i-1] : e[i];
    end
  end

  assign value_o = value;

  always_ff @(posedge clk_i) begin
    if (req_i.commit) begin
      mem[cur_i] <= row_new;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= '1;
    end else if (clear_i) begin
      fresh_q <= '1;
    end else if (req_i.commit) begin
      fresh_q[cur_i] <= 1'b0;
    end
  end
endmodule

@@ rtl/mtf_lz_pixel_channel_decoder_core.sv @@
// Move-to-front / copy decoder for one 8-bit image channel.
// Input words (s_axis): tuser carries the kind (bit, tick, start keeping
// rows, start clearing rows); tdata[0] carries the stream bit.
// Output words (m_axis): one per input word. tuser flags a pixel, tlast
// marks the final pixel of the channel, tdata holds pixel, need_bit and
// status.
// Configuration (cfg_*) sets line width and line count; both are latched
// at a channel start and must be written only while the decoder is idle,
// which the block does not enforce. One word is taken per cycle unless
// the receiver stalls. Literals use the previous byte's recent row,
// prefetched from a 256x64 synchronous memory; copies read a prefetched
// history ring, with forwarding of the byte written in the same cycle.
// After reset the decoder is idle and all recent rows read as identity.
// A single output register decouples the sides: when the receiver stalls
// with a word held, s_axis_tready drops until it is taken.
module mtf_lz_pixel_channel_decoder_core #(
  parameter int unsigned MAX_WIDTH     = 2048,
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // bit_value, zero pad
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel, need_bit, status, zero pad
  output logic        m_axis_tuser,   // pixel_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mlpd_pkg::*;

  localparam int unsigned DW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RAW     = 4'd1;
  localparam logic [3:0] PH_PFX1    = 4'd2;
  localparam logic [3:0] PH_PFX2    = 4'd3;
  localparam logic [3:0] PH_SEL     = 4'd4;
  localparam logic [3:0] PH_LITFLAG = 4'd5;
  localparam logic [3:0] PH_LITRAW  = 4'd6;
  localparam logic [3:0] PH_LITIDX  = 4'd7;
  localparam logic [3:0] PH_C2      = 4'd8;
  localparam logic [3:0] PH_C4      = 4'd9;
  localparam logic [3:0] PH_C8      = 4'd10;
  localparam logic [3:0] PH_C16     = 4'd11;
  localparam logic [3:0] PH_CHI     = 4'hC;
  localparam logic [3:0] PH_CLO     = 4'hD;
  localparam logic [3:0] PH_COPY    = 4'hE;

  logic [11:0]      lw_q;
  logic [15:0]      lc_q;
  logic [3:0]       phase_q, phase_d;
  logic [15:0]      acc_q, acc_d;
  logic [4:0]       rem_q, rem_d;
  logic [15:0]      upper_q, upper_d;
  logic [POS_W-1:0] crem_q, crem_d;
  logic [DW-1:0]    dist_q, dist_d;
  logic [DW-1:0]    cw_q, cw_d;
  logic [POS_W-1:0] tot_q, tot_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       prev_q, prev_d;

  logic             out_valid_q;
  logic [7:0]       out_pixel_q;
  logic             out_pv_q, out_done_q, out_need_q;
  logic [1:0]       out_status_q;

  logic             s_acc;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [1:0]       status;
  logic             clear;
  mtf_req_t         mtf_req;
  logic [7:0]       lit_value;
  logic [7:0]       hist_rdata;
  logic [15:0]      acc_n;
  logic [4:0]       rem_n;
  logic [31:0]      count;
  logic             start_cnt;
  logic [POS_W-1:0] left;
  logic             last_px;
  logic [DW-1:0]    wsel;
  logic [POS_W-1:0] crem_n;
  logic [POS_W-1:0] raddr_full;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign acc_n         = {acc_q[14:0], s_axis_tdata[0]};
  assign rem_n         = (rem_q != 5'd0) ? rem_q - 5'd1 : 5'd0;
  assign left          = tot_q - pos_q;
  assign last_px       = (pos_q + POS_W'(1)) >= tot_q;
  assign crem_n        = crem_q - POS_W'(1);

  always_comb begin
    if (lw_q == 12'd0) begin
      wsel = DW'(1);
    end else if (32'(lw_q) > MAX_WIDTH) begin
      wsel = DW'(MAX_WIDTH);
    end else begin
      wsel = DW'(lw_q);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    upper_d   = upper_q;
    crem_d    = crem_q;
    dist_d    = dist_q;
    cw_d      = cw_q;
    tot_d     = tot_q;
    pos_d     = pos_q;
    prev_d    = prev_q;
    emit      = 1'b0;
    emit_byte = 8'd0;
    status    = ST_OK;
    clear     = 1'b0;
    mtf_req   = '0;
    count     = 32'd0;
    start_cnt = 1'b0;
    if (s_acc) begin
      if (s_axis_tuser == MODE_START_KEEP || s_axis_tuser == MODE_START_CLR) begin
        clear   = (s_axis_tuser == MODE_START_CLR);
        cw_d    = wsel;
        tot_d   = POS_W'(wsel * ((lc_q == 16'd0) ? 16'd1 : lc_q));
        pos_d   = '0;
        crem_d  = '0;
        upper_d = '0;
        dist_d  = '0;
        phase_d = PH_RAW;
        acc_d   = '0;
        rem_d   = 5'd8;
      end else if (phase_q == PH_IDLE) begin
        status = ST_UNEXPECT;
      end else if (phase_q == PH_COPY) begin
        if (s_axis_tuser != MODE_TICK) begin
          status = ST_UNEXPECT;
        end else begin
          emit   = 1'b1;
          crem_d = crem_n;
          if (dist_q == '0) begin
            emit_byte = 8'd0;
          end else if (POS_W'(dist_q) > pos_q) begin
            emit_byte = 8'd0;
            status    = ST_BEFORE;
          end else begin
            emit_byte = hist_rdata;
          end
          if (crem_n == '0) begin
            phase_d = PH_PFX1;
            acc_d   = '0;
            rem_d   = 5'd1;
          end
        end
      end else if (s_axis_tuser != MODE_BIT) begin
        status = ST_UNEXPECT;
      end else begin
        acc_d = acc_n;
        rem_d = rem_n;
        if (rem_n == 5'd0) begin
          acc_d = '0;
          case (phase_q)
            PH_RAW: begin
              emit      = 1'b1;
              emit_byte = acc_n[7:0];
              phase_d   = (pos_q == '0) ? PH_RAW : PH_PFX1;
              rem_d     = (pos_q == '0) ? 5'd8 : 5'd1;
            end
            PH_PFX1: begin
              phase_d = acc_n[0] ? PH_PFX2 : PH_LITFLAG;
              rem_d   = 5'd1;
            end
            PH_PFX2: begin
              if (acc_n[0]) begin
                phase_d = PH_SEL;
              end else begin
                dist_d  = DW'(1);
                phase_d = PH_C2;
              end
              rem_d = 5'd2;
            end
            PH_SEL: begin
              case (acc_n[1:0])
                2'd0:    dist_d = cw_q;
                2'd1:    dist_d = cw_q - DW'(1);
                2'd2:    dist_d = cw_q + DW'(1);
                default: dist_d = DW'(2);
              endcase
              phase_d = PH_C2;
              rem_d   = 5'd2;
            end
            PH_LITFLAG: begin
              phase_d = acc_n[0] ? PH_LITRAW : PH_LITIDX;
              rem_d   = acc_n[0] ? 5'd8 : 5'd3;
            end
            PH_LITRAW, PH_LITIDX: begin
              mtf_req.commit   = 1'b1;
              mtf_req.is_index = (phase_q == PH_LITIDX);
              mtf_req.val      = acc_n[7:0];
              emit             = 1'b1;
              emit_byte        = lit_value;
              phase_d          = PH_PFX1;
              rem_d            = 5'd1;
            end
            PH_C2: begin
              if (acc_n[1:0] != 2'd0) begin
                start_cnt = 1'b1;
                count     = 32'(acc_n[1:0]);
              end else begin
                phase_d = PH_C4;
                rem_d   = 5'd4;
              end
            end
            PH_C4: begin
              if (acc_n[3:0] != 4'd0) begin
                start_cnt = 1'b1;
                count     = 32'(acc_n[3:0]) + 32'd3;
              end else begin
                phase_d = PH_C8;
                rem_d   = 5'd8;
              end
            end
            PH_C8: begin
              if (acc_n[7:0] != 8'd0) begin
                start_cnt = 1'b1;
                count     = 32'(acc_n[7:0]);
              end else begin
                phase_d = PH_C16;
                rem_d   = 5'd16;
              end
            end
            PH_C16: begin
              if (acc_n != 16'd0) begin
                start_cnt = 1'b1;
                count     = 32'(acc_n);
              end else begin
                phase_d = PH_CHI;
                rem_d   = 5'd16;
              end
            end
            PH_CHI: begin
              upper_d = acc_n;
              phase_d = PH_CLO;
              rem_d   = 5'd16;
            end
            PH_CLO: begin
              start_cnt = 1'b1;
              count     = {upper_q, acc_n};
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
          if (start_cnt) begin
            if (count > 32'(left)) begin
              count  = 32'(left);
              status = ST_TRUNC;
            end
            if (count == 32'd0) begin
              phase_d = PH_PFX1;
              rem_d   = 5'd1;
            end else begin
              crem_d  = POS_W'(count);
              phase_d = PH_COPY;
            end
          end
        end
      end
    end
    if (emit) begin
      pos_d  = pos_q + POS_W'(1);
      prev_d = emit_byte;
      if (last_px) begin
        phase_d = PH_IDLE;
      end
    end
  end

  assign raddr_full = pos_d - POS_W'(dist_d);

  mlpd_history #(
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (emit),
    .waddr_i(pos_q[AW-1:0]),
    .wdata_i(emit_byte),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(hist_rdata)
  );

  mlpd_rows u_rows (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raddr_i(prev_d),
    .cur_i  (prev_q),
    .clear_i(clear),
    .req_i  (mtf_req),
    .value_o(lit_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q    <= 12'd1;
      lc_q    <= 16'd1;
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      rem_q   <= '0;
      upper_q <= '0;
      crem_q  <= '0;
      dist_q  <= '0;
      cw_q    <= DW'(1);
      tot_q   <= POS_W'(1);
      pos_q   <= '0;
      prev_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_LINE_WIDTH) begin
          lw_q <= cfg_data_i[11:0];
        end else begin
          lc_q <= cfg_data_i;
        end
      end
      phase_q <= phase_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      upper_q <= upper_d;
      crem_q  <= crem_d;
      dist_q  <= dist_d;
      cw_q    <= cw_d;
      tot_q   <= tot_d;
      pos_q   <= pos_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_pv_q     <= emit;
      out_pixel_q  <= emit_byte;
      out_done_q   <= emit && last_px;
      out_need_q   <= (phase_d != PH_IDLE) && (phase_d != PH_COPY);
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_status_q, out_need_q, out_pixel_q};
  assign m_axis_tuser  = out_pv_q;
  assign m_axis_tlast  = out_done_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready) else $error("input stalled with empty output");

  a_done_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser) else $error("done without pixel");

  a_copy_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_COPY |-> crem_q != '0) else $error("copy with zero count");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> pos_q < tot_q) else $error("position past channel end");
endmodule
